// ===== hw/rtl/lnsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsc_pkg
// Shared types and constants of the letterbox nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package lnsc_pkg;

	// Default sizes of the frame store and the largest window.
	localparam int DEF_MAX_FRAME_WIDTH  = 512;
	localparam int DEF_MAX_FRAME_HEIGHT = 256;
	localparam int DEF_MAX_WINDOW_DIM   = 4096;

	// Fixed field widths.
	localparam int COORD_W   = 12;
	localparam int PIXEL_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int ASPECT_FRAC = 12;

	// Opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y      = 3'd6;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [PIXEL_W-1:0] pixel_in;
	} in_beat_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_out;
		logic               in_picture;
	} out_beat_t;

endpackage

// ===== hw/rtl/letterbox_nearest_scaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_core
// Frame store plus nearest-neighbor scaler with letterbox bars.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the registered stages s1 to s7 to its result beat.
// Throughput: one beat per cycle while the result output is not stalled, loads and requests mixed freely.
// After reset and after each config write, in_ready stays low while the shared
// bit-serial divider derives the rectangle and two reciprocals.
// Reset is asynchronous and clears control state; the frame store is not cleared.
module letterbox_nearest_scaler_core
	import lnsc_pkg::*;
#(
	parameter int MAX_FRAME_WIDTH  = DEF_MAX_FRAME_WIDTH,
	parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT,
	parameter int MAX_WINDOW_DIM   = DEF_MAX_WINDOW_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_beat,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// Widths of saturated sizes, window dimensions and products.
	localparam int XW    = $clog2(MAX_FRAME_WIDTH + 1);
	localparam int YW    = $clog2(MAX_FRAME_HEIGHT + 1);
	localparam int FXW   = (XW > YW) ? XW : YW;
	localparam int WDW   = $clog2(MAX_WINDOW_DIM + 1);
	localparam int CMW   = ((WDW > COORD_W) ? WDW : COORD_W) + 1;
	// n = d * frame stays below 2^K, so floor(n * floor(2^K/r) / 2^K) is at
	// most one below floor(n / r).
	localparam int K     = WDW + FXW;
	localparam int RCW   = K + 1;
	localparam int PW    = WDW + 17;
	localparam int DIV_N_W = ((WDW + ASPECT_FRAC) > RCW) ? (WDW + ASPECT_FRAC) : RCW;
	localparam int DIV_D_W = (WDW > 16) ? WDW : 16;
	localparam int DCW   = $clog2(DIV_N_W + 1);
	localparam int DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers, reset to the power-on picture setup.
	// ------------------------------------------------------------------
	logic [9:0]  frame_width_q;
	logic [8:0]  frame_height_q;
	logic [12:0] window_width_q;
	logic [12:0] window_height_q;
	logic [15:0] aspect_ratio_q;
	logic        mirror_x_q;
	logic        mirror_y_q;
	logic        cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= 10'd320;
			frame_height_q  <= 9'd240;
			window_width_q  <= 13'd320;
			window_height_q <= 13'd240;
			aspect_ratio_q  <= 16'd5461;
			mirror_x_q      <= 1'b0;
			mirror_y_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[9:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[8:0];
				REG_WINDOW_WIDTH:  window_width_q  <= cfg_data[12:0];
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data[12:0];
				REG_ASPECT_RATIO:  aspect_ratio_q  <= cfg_data;
				REG_MIRROR_X:      mirror_x_q      <= cfg_data[0];
				REG_MIRROR_Y:      mirror_y_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate register values into their legal ranges.
	logic [31:0] fw_w, fh_w, ww_w, wh_w;
	logic [XW-1:0]  fw_c;
	logic [YW-1:0]  fh_c;
	logic [WDW-1:0] ww_c, wh_c;
	logic [15:0]    ar_c;
	logic           copy_11;

	always_comb begin
		fw_w = 32'(frame_width_q);
		fh_w = 32'(frame_height_q);
		ww_w = 32'(window_width_q);
		wh_w = 32'(window_height_q);
		if (fw_w == 32'd0) fw_w = 32'd1;
		else if (fw_w > 32'(MAX_FRAME_WIDTH)) fw_w = 32'(MAX_FRAME_WIDTH);
		if (fh_w == 32'd0) fh_w = 32'd1;
		else if (fh_w > 32'(MAX_FRAME_HEIGHT)) fh_w = 32'(MAX_FRAME_HEIGHT);
		if (ww_w == 32'd0) ww_w = 32'd1;
		else if (ww_w > 32'(MAX_WINDOW_DIM)) ww_w = 32'(MAX_WINDOW_DIM);
		if (wh_w == 32'd0) wh_w = 32'd1;
		else if (wh_w > 32'(MAX_WINDOW_DIM)) wh_w = 32'(MAX_WINDOW_DIM);
		fw_c    = XW'(fw_w);
		fh_c    = YW'(fh_w);
		ww_c    = WDW'(ww_w);
		wh_c    = WDW'(wh_w);
		ar_c    = (aspect_ratio_q == 16'd0) ? 16'd1 : aspect_ratio_q;
		copy_11 = (fw_w == ww_w) && (fh_w == wh_w);
	end

	// Aspect compare: window wider than the display aspect.
	logic [PW-1:0]  asp_lhs, asp_rhs;
	logic           wide;
	logic [WDW-1:0] rw_wide;

	assign asp_lhs = PW'(ww_c) << ASPECT_FRAC;
	assign asp_rhs = PW'(ar_c) * PW'(wh_c);
	assign wide    = asp_lhs > asp_rhs;
	assign rw_wide = WDW'(asp_rhs >> ASPECT_FRAC);

	// ------------------------------------------------------------------
	// Setup sequencer and shared restoring divider
	// ------------------------------------------------------------------
	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_PREP = 5'b00010,
		C_DIVH = 5'b00100,
		C_RECX = 5'b01000,
		C_RECY = 5'b10000
	} cfg_state_t;

	cfg_state_t cstate_q;

	logic [XW-1:0]      fw_q;
	logic [YW-1:0]      fh_q;
	logic [WDW-1:0]     ww_q, wh_q;
	logic [WDW-1:0]     rw_q, rh_q, rx_q, ry_q;
	logic               zr_q;
	logic [RCW-1:0]     recx_q, recy_q;

	logic               div_busy_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [DIV_N_W-1:0] div_quo_q;
	logic [DIV_D_W-1:0] div_rem_q;
	logic [DIV_D_W-1:0] div_den_q;
	logic               div_go;
	logic               div_done;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_D_W:0]   div_trial;

	assign div_done  = div_busy_q && (div_cnt_q == DCW'(0));
	assign div_trial = {div_rem_q, div_quo_q[DIV_N_W-1]};

	always_comb begin
		div_go  = 1'b0;
		div_num = DIV_N_W'(1) << K;
		div_den = DIV_D_W'(rw_q);
		unique case (cstate_q)
			C_DIVH: begin
				div_go  = !div_busy_q;
				div_num = DIV_N_W'(ww_q) << ASPECT_FRAC;
				div_den = DIV_D_W'(ar_c);
			end
			C_RECX: begin
				div_go  = !div_busy_q;
				div_den = DIV_D_W'(rw_q);
			end
			C_RECY: begin
				div_go  = !div_busy_q;
				div_den = DIV_D_W'(rh_q);
			end
			default: ;
		endcase
	end

	// Shift one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cfg_wr) begin
			div_busy_q <= 1'b0;
		end else if (div_go) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= DCW'(DIV_N_W);
		end else if (div_busy_q) begin
			if (div_done) div_busy_q <= 1'b0;
			else div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_quo_q <= div_num;
			div_rem_q <= '0;
			div_den_q <= div_den;
		end else if (div_busy_q && !div_done) begin
			if (div_trial >= {1'b0, div_den_q}) begin
				div_rem_q <= DIV_D_W'(div_trial - {1'b0, div_den_q});
				div_quo_q <= {div_quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				div_rem_q <= DIV_D_W'(div_trial);
				div_quo_q <= {div_quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	// Derive rectangle, offsets and reciprocals; a write restarts the pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstate_q <= C_PREP;
			zr_q     <= 1'b0;
		end else if (cfg_wr) begin
			cstate_q <= C_PREP;
		end else begin
			unique case (cstate_q)
				C_IDLE: ;
				C_PREP: begin
					zr_q <= 1'b0;
					if (copy_11) begin
						cstate_q <= C_RECX;
					end else if (wide) begin
						if (rw_wide == '0) begin
							zr_q     <= 1'b1;
							cstate_q <= C_IDLE;
						end else begin
							cstate_q <= C_RECX;
						end
					end else begin
						cstate_q <= C_DIVH;
					end
				end
				C_DIVH: begin
					if (div_done) begin
						if (WDW'(div_quo_q) == '0) begin
							zr_q     <= 1'b1;
							cstate_q <= C_IDLE;
						end else begin
							cstate_q <= C_RECX;
						end
					end
				end
				C_RECX: if (div_done) cstate_q <= C_RECY;
				C_RECY: if (div_done) cstate_q <= C_IDLE;
				default: cstate_q <= C_PREP;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cstate_q == C_PREP) begin
			fw_q <= fw_c;
			fh_q <= fh_c;
			ww_q <= ww_c;
			wh_q <= wh_c;
			if (copy_11) begin
				rw_q <= ww_c;
				rh_q <= wh_c;
				rx_q <= '0;
				ry_q <= '0;
			end else if (wide) begin
				rw_q <= rw_wide;
				rh_q <= wh_c;
				rx_q <= WDW'((ww_c - rw_wide) >> 1);
				ry_q <= '0;
			end else begin
				rw_q <= ww_c;
				rx_q <= '0;
			end
		end
		if (cstate_q == C_DIVH && div_done) begin
			rh_q <= WDW'(div_quo_q);
			ry_q <= WDW'((wh_q - WDW'(div_quo_q)) >> 1);
		end
		if (cstate_q == C_RECX && div_done) recx_q <= RCW'(div_quo_q);
		if (cstate_q == C_RECY && div_done) recy_q <= RCW'(div_quo_q);
	end

	// Copy paths (rectangle equals frame) ignore the mirrors.
	logic copy_any, mx_eff, my_eff;
	assign copy_any = (rw_q == WDW'(fw_q)) && (rh_q == WDW'(fh_q));
	assign mx_eff   = mirror_x_q && !copy_any;
	assign my_eff   = mirror_y_q && !copy_any;

	// ------------------------------------------------------------------
	// Pixel pipeline: s1 input, s2 rectangle, s3 d*frame, s4 reciprocal,
	// s5 remainder, s6 address, s7 store access / output register.
	// ------------------------------------------------------------------
	logic adv, in_acc;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic               op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic [COORD_W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [COORD_W-1:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	logic [PIXEL_W-1:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;
	logic               ins_s2, ins_s3, ins_s4, ins_s5, ins_s6, ins_s7;

	assign adv      = !vld_s7 || out_ready;
	assign in_ready = adv && (cstate_q == C_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6 && (op_s6 == OP_READ);
		end
	end

	// Stage 1: capture the beat.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= in_beat.opcode;
			x_s1   <= in_beat.coord_x;
			y_s1   <= in_beat.coord_y;
			pix_s1 <= in_beat.pixel_in;
		end
	end

	// Stage 2: locate inside the rectangle and mirror.
	logic [CMW-1:0] xe, ye, oxe, oye;
	logic [WDW-1:0] ox, oy, dx_c, dy_c;
	logic           in_x, in_y;
	logic [WDW-1:0] dx_s2, dy_s2;

	always_comb begin
		xe   = CMW'(x_s1);
		ye   = CMW'(y_s1);
		oxe  = xe - CMW'(rx_q);
		oye  = ye - CMW'(ry_q);
		in_x = (xe < CMW'(ww_q)) && (xe >= CMW'(rx_q)) && (oxe < CMW'(rw_q));
		in_y = (ye < CMW'(wh_q)) && (ye >= CMW'(ry_q)) && (oye < CMW'(rh_q));
		ox   = WDW'(oxe);
		oy   = WDW'(oye);
		dx_c = mx_eff ? (rw_q - WDW'(1) - ox) : ox;
		dy_c = my_eff ? (rh_q - WDW'(1) - oy) : oy;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2  <= op_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			pix_s2 <= pix_s1;
			ins_s2 <= in_x && in_y && !zr_q;
			dx_s2  <= dx_c;
			dy_s2  <= dy_c;
		end
	end

	// Stage 3: n = d * frame.
	logic [K-1:0] nx_s3, ny_s3, nx_s4, ny_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3  <= op_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			pix_s3 <= pix_s2;
			ins_s3 <= ins_s2;
			nx_s3  <= K'(dx_s2) * K'(fw_q);
			ny_s3  <= K'(dy_s2) * K'(fh_q);
		end
	end

	// Stage 4: quotient estimate via reciprocal.
	logic [K+RCW-1:0] px, py;
	logic [XW-1:0]    qx0_s4, qx0_s5;
	logic [YW-1:0]    qy0_s4, qy0_s5;

	assign px = (K+RCW)'(nx_s3) * (K+RCW)'(recx_q);
	assign py = (K+RCW)'(ny_s3) * (K+RCW)'(recy_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4  <= op_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			pix_s4 <= pix_s3;
			ins_s4 <= ins_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			qx0_s4 <= px[K +: XW];
			qy0_s4 <= py[K +: YW];
		end
	end

	// Stage 5: remainder of the estimate.
	logic [K-1:0] remx_s5, remy_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5   <= op_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			pix_s5  <= pix_s4;
			ins_s5  <= ins_s4;
			qx0_s5  <= qx0_s4;
			qy0_s5  <= qy0_s4;
			remx_s5 <= nx_s4 - K'(qx0_s4) * K'(rw_q);
			remy_s5 <= ny_s4 - K'(qy0_s4) * K'(rh_q);
		end
	end

	// Stage 6: correct by one and form the store address. The quotient
	// stays below the frame size since d < rect, so no clamp is needed.
	logic [XW-1:0] qx;
	logic [YW-1:0] qy;
	logic          ld_ok;
	logic [AW-1:0] addr_s6;
	logic          we_s6;

	assign qx    = qx0_s5 + XW'(remx_s5 >= K'(rw_q));
	assign qy    = qy0_s5 + YW'(remy_s5 >= K'(rh_q));
	assign ld_ok = (32'(x_s5) < 32'(MAX_FRAME_WIDTH)) && (32'(y_s5) < 32'(MAX_FRAME_HEIGHT));

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s6  <= op_s5;
			pix_s6 <= pix_s5;
			ins_s6 <= ins_s5;
			we_s6  <= (op_s5 == OP_LOAD) && ld_ok;
			if (op_s5 == OP_LOAD)
				addr_s6 <= AW'(AW'(y_s5) * AW'(MAX_FRAME_WIDTH) + AW'(x_s5));
			else
				addr_s6 <= AW'(AW'(qy) * AW'(MAX_FRAME_WIDTH) + AW'(qx));
		end
	end

	// Stage 7: frame store, one write or one read per cycle while the pipeline advances.
	logic [PIXEL_W-1:0] store_mem [DEPTH];
	logic [PIXEL_W-1:0] rd_s7;

	always_ff @(posedge clk) begin
		if (adv && vld_s6) begin
			if (we_s6) store_mem[addr_s6] <= pix_s6;
			else rd_s7 <= store_mem[addr_s6];
			ins_s7 <= ins_s6;
		end
	end

	// Drive bars black.
	assign out_valid           = vld_s7;
	assign out_beat.in_picture = ins_s7;
	assign out_beat.pixel_out  = ins_s7 ? rd_s7 : '0;

endmodule

// ===== hw/rtl/lnsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsc_checker
// Port-level checks of the scaler core, bound to the scaler core module.
// ----------------------------------------------------------------------------
module lnsc_checker
	import lnsc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input in_beat_t             in_beat,
	input logic                 out_valid,
	input logic                 out_ready,
	input out_beat_t            out_beat,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	// Hold a stalled result beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("result beat dropped or changed under stall");

	// Bars are black.
	a_bar_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.in_picture |-> out_beat.pixel_out == '0)
		else $error("pixel outside picture is not black");

	// A config write blocks input while setup reruns.
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input accepted right after a config write");

	// No input right out of reset.
	a_rst_block: assert property (@(posedge clk)
		$rose(arst_n) |-> !in_ready && !out_valid)
		else $error("core ready right after reset");

endmodule

bind letterbox_nearest_scaler_core lnsc_checker u_lnsc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the letterbox nearest-neighbor scaler core. Run
// directed and random loads and window requests under several register
// settings and idling mixes, loading any source entry a request needs first.
// Check every result beat against an in-bench scaler model.
// ----------------------------------------------------------------------------
module tb_top;
	import lnsc_pkg::*;

	localparam int STORE_W = DEF_MAX_FRAME_WIDTH;
	localparam int STORE_H = DEF_MAX_FRAME_HEIGHT;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;

	// Model of the scaler plus the queue of window pixels still owed.
	class pixel_scoreboard;
		bit [15:0] frame_mem [STORE_W*STORE_H];
		bit written [STORE_W*STORE_H];
		int unsigned fw_reg, fh_reg, ww_reg, wh_reg, ar_reg;
		bit mx_reg, my_reg;
		out_beat_t owed [$];
		int errors;

		function new();
			fw_reg = 320; fh_reg = 240; ww_reg = 320; wh_reg = 240;
			ar_reg = 5461; mx_reg = 0; my_reg = 0; errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
			case (idx)
				REG_FRAME_WIDTH:   fw_reg = 32'(d[9:0]);
				REG_FRAME_HEIGHT:  fh_reg = 32'(d[8:0]);
				REG_WINDOW_WIDTH:  ww_reg = 32'(d[12:0]);
				REG_WINDOW_HEIGHT: wh_reg = 32'(d[12:0]);
				REG_ASPECT_RATIO:  ar_reg = 32'(d);
				REG_MIRROR_X:      mx_reg = d[0];
				REG_MIRROR_Y:      my_reg = d[0];
				default: ;
			endcase
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			return (v < 1) ? 1 : ((v > hi) ? hi : v);
		endfunction

		// Nearest source index for offset d inside a rectangle span.
		function int unsigned src_index(int unsigned d, int unsigned span,
			int unsigned frame, bit flip);
			longint unsigned dd, s;
			dd = 64'(flip ? (span - 1 - d) : d);
			s = (dd * 64'(frame)) / 64'(span);
			if (s >= 64'(frame)) s = 64'(frame - 1);
			return 32'(s);
		endfunction

		// Store entry shown at a window coordinate, or -1 for a bar.
		function int target(int unsigned x, int unsigned y);
			int unsigned fw, fh, ww, wh, ar, rx, ry, rw, rh, sx, sy;
			fw = clip(fw_reg, STORE_W); fh = clip(fh_reg, STORE_H);
			ww = clip(ww_reg, DEF_MAX_WINDOW_DIM); wh = clip(wh_reg, DEF_MAX_WINDOW_DIM);
			ar = (ar_reg == 0) ? 1 : ar_reg;
			rx = 0; ry = 0; rw = ww; rh = wh;
			if (x >= ww || y >= wh) return -1;
			if (fw == ww && fh == wh) return int'(y*STORE_W + x);
			if (64'(ww) * 64'(4096) > 64'(ar) * 64'(wh)) begin
				rw = 32'((64'(wh) * 64'(ar)) / 64'(4096));
				rx = (ww - rw) / 2;
			end else begin
				rh = 32'((64'(ww) * 64'(4096)) / 64'(ar));
				ry = (wh - rh) / 2;
			end
			if (rw == 0 || rh == 0 || x < rx || x - rx >= rw || y < ry || y - ry >= rh)
				return -1;
			if (rw == fw && rh == fh) begin
				sx = x - rx;
				sy = y - ry;
			end else begin
				sx = src_index(x - rx, rw, fw, mx_reg);
				sy = src_index(y - ry, rh, fh, my_reg);
			end
			return int'(sy*STORE_W + sx);
		endfunction

		function out_beat_t window_pixel(int unsigned x, int unsigned y);
			out_beat_t r;
			int a;
			r = '0;
			a = target(x, y);
			if (a >= 0) begin
				r.in_picture = 1'b1;
				r.pixel_out = frame_mem[a];
			end
			return r;
		endfunction

		function void note_input(in_beat_t b);
			if (b.opcode == OP_LOAD) begin
				if (b.coord_x < STORE_W && b.coord_y < STORE_H) begin
					frame_mem[b.coord_y*STORE_W + b.coord_x] = b.pixel_in;
					written[b.coord_y*STORE_W + b.coord_x] = 1'b1;
				end
			end else
				owed.push_back(window_pixel(32'(b.coord_x), 32'(b.coord_y)));
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$display("%0t: pixel_out expected %h actual %h", $time,
					want.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.in_picture !== want.in_picture) begin
				$display("%0t: in_picture expected %b actual %b", $time,
					want.in_picture, got.in_picture);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_beat_t in_beat = '0;
	logic out_valid;
	logic out_ready = 0;
	out_beat_t out_beat;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;

	letterbox_nearest_scaler_core dut (.*);

	always #10 clk = ~clk;

	// Sample result beats at the rising edge.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(out_beat);

	// Receiver: random stalls, plus a long hold each time one is requested.
	always @(negedge clk) begin : receiver
		int hold_left;
		int hold_seen;
		if (hold_req != hold_seen) begin
			hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
		end
		if (hold_left > 0) begin
			out_ready <= 0;
			hold_left--;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one beat, idling first at random; return once accepted.
	task automatic send_beat(in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 0;
		end
		@(negedge clk);
		in_valid <= 1;
		in_beat <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
	endtask

	task automatic pixel_load(int unsigned x, int unsigned y, int unsigned p);
		in_beat_t b;
		b.opcode = OP_LOAD; b.coord_x = COORD_W'(x); b.coord_y = COORD_W'(y);
		b.pixel_in = PIXEL_W'(p);
		send_beat(b);
	endtask

	// Load the source entry first if the request would show an unwritten one.
	task automatic pixel_request(int unsigned x, int unsigned y);
		in_beat_t b;
		int a;
		a = sb.target(x, y);
		if (a >= 0 && !sb.written[a])
			pixel_load(a % STORE_W, a / STORE_W, $urandom);
		b.opcode = OP_READ; b.coord_x = COORD_W'(x); b.coord_y = COORD_W'(y);
		b.pixel_in = PIXEL_W'($urandom);
		send_beat(b);
	endtask

	// Drop valid and hold until every owed result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	// Write one register while idle; wait out in-flight loads first.
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_geometry(int fw, int fh, int ww, int wh, int ar, bit mx, bit my);
		reg_write(REG_FRAME_WIDTH, CFG_DAT_W'(fw));
		reg_write(REG_FRAME_HEIGHT, CFG_DAT_W'(fh));
		reg_write(REG_WINDOW_WIDTH, CFG_DAT_W'(ww));
		reg_write(REG_WINDOW_HEIGHT, CFG_DAT_W'(wh));
		reg_write(REG_ASPECT_RATIO, CFG_DAT_W'(ar));
		reg_write(REG_MIRROR_X, CFG_DAT_W'(mx));
		reg_write(REG_MIRROR_Y, CFG_DAT_W'(my));
	endtask

	// Random mix of loads and requests, aimed mostly at the window.
	task automatic random_traffic(int n);
		int unsigned span_x, span_y;
		span_x = (sb.ww_reg + 3 > 4095) ? 4095 : sb.ww_reg + 3;
		span_y = (sb.wh_reg + 3 > 4095) ? 4095 : sb.wh_reg + 3;
		repeat (n) begin
			case ($urandom_range(9))
				0: pixel_load($urandom_range(4095), $urandom_range(4095), $urandom);
				1, 2: pixel_load($urandom_range(520), $urandom_range(260), $urandom);
				3: pixel_request($urandom_range(4095), $urandom_range(4095));
				default: pixel_request($urandom_range(span_x), $urandom_range(span_y));
			endcase
		end
	endtask

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1;

		// Directed: reset geometry is a 1:1 copy; hit store and window edges.
		pixel_load(511, 255, 'hFFFF);
		pixel_load(0, 0, 'h0000);
		pixel_load(512, 0, 'h1234);
		pixel_load(0, 256, 'h4321);
		pixel_load(4095, 4095, 'hFFFF);
		pixel_request(0, 0);
		pixel_request(319, 239);
		pixel_request(320, 0);
		pixel_request(0, 240);
		pixel_request(4095, 4095);

		// Extremes: saturated frame, largest window, both mirrors.
		set_geometry('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 4096, 1, 1);
		pixel_request(0, 0);
		pixel_request(4095, 4095);
		pixel_request(2048, 1);
		// Zero frame/window sizes saturate to one; 1:1 copy of a single pixel.
		set_geometry(0, 0, 0, 0, 0, 1, 0);
		pixel_request(0, 0);
		pixel_request(1, 0);
		reg_write(REG_UNUSED, 16'hFFFF);
		// Offset copy: rectangle matches the frame, centered with bars.
		set_geometry(256, 256, 300, 256, 4096, 1, 1);
		pixel_request(21, 0);
		pixel_request(22, 0);
		pixel_request(277, 255);
		pixel_request(278, 255);
		// Zero-height rectangle: all black.
		set_geometry(64, 64, 1, 4096, 65535, 0, 0);
		pixel_request(0, 2048);

		// Random phases, cycling through idling mixes.
		for (int p = 0; p < 10; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 76; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 76; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase
			if (p == 0)
				set_geometry(320, 240, 320, 240, 5461, 0, 0);
			else if (p == 9)
				set_geometry(512, 256, 4096, 4096, 65535, 1, 1);
			else if ($urandom_range(1))
				set_geometry($urandom_range(1, 96), $urandom_range(1, 64),
					$urandom_range(1, 160), $urandom_range(1, 128),
					$urandom_range(2048, 12288), $urandom_range(1), $urandom_range(1));
			else
				set_geometry($urandom_range(0, 1023), $urandom_range(0, 511),
					$urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 65535), $urandom_range(1), $urandom_range(1));
			random_traffic(55);
			if (p % 4 == 0) begin
				// Long receiver hold while requests keep coming: fill and stall.
				hold_req++;
				random_traffic(35);
			end
			// Pause until everything owed is back.
			drain();
			random_traffic(60);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
